[hdl/fcsg_pkg.sv]
package fcsg_pkg;

  localparam int CoordWidth  = 11;
  localparam int RadiusWidth = 5;
  localparam int ColourWidth = 24;
  localparam int SpanXyWidth = 13;
  localparam int SpanWWidth  = 6;
  localparam int DecWidth    = 10;
  localparam int PosWidth    = 6;

  // Four spans per midpoint step, at most 64 spans per disc.
  localparam int MaxSpans  = 64;
  localparam int StepLimit = MaxSpans / 4;
  localparam int StepWidth = $clog2(StepLimit);

  localparam int QueueDepth = 2;

  // One classified disc request, as it waits between front and back.
  typedef struct packed {
    logic [CoordWidth-1:0]      cx;
    logic [CoordWidth-1:0]      cy;
    logic [RadiusWidth-1:0]     r;
    logic signed [DecWidth-1:0] d0;
    logic [ColourWidth-1:0]     colour;
  } req_t;

endpackage

[hdl/fcsg_front.sv]
module fcsg_front #(
  parameter int MAX_RADIUS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [fcsg_pkg::CoordWidth-1:0]     centre_x,
  input  logic [fcsg_pkg::CoordWidth-1:0]     centre_y,
  input  logic [fcsg_pkg::RadiusWidth-1:0]    radius,
  input  logic [fcsg_pkg::ColourWidth-1:0]    fill_colour,
  output logic                                req_valid,
  input  logic                                req_take,
  output fcsg_pkg::req_t                      req
);
  import fcsg_pkg::*;

  localparam int PtrWidth = $clog2(QueueDepth);

  req_t                   classified;
  logic [RadiusWidth-1:0] r_sat;
  req_t                   mem [QueueDepth];
  logic [PtrWidth-1:0]    wr_ptr;
  logic [PtrWidth-1:0]    rd_ptr;
  logic [PtrWidth:0]      count;
  logic                   wr_en;
  logic                   rd_en;

  // Clamp the radius and seed the decision term.
  always_comb begin
    r_sat = (radius > RadiusWidth'(MAX_RADIUS)) ? RadiusWidth'(MAX_RADIUS) : radius;
    classified.cx     = centre_x;
    classified.cy     = centre_y;
    classified.r      = r_sat;
    classified.d0     = $signed(DecWidth'(3)) -
                        $signed({{(DecWidth-RadiusWidth-1){1'b0}}, r_sat, 1'b0});
    classified.colour = fill_colour;
  end

  assign full      = (count == (PtrWidth+1)'(QueueDepth));
  assign req_valid = (count != '0);
  assign wr_en     = push && !full;
  assign rd_en     = req_take && req_valid;
  assign req       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrWidth'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrWidth'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrWidth+1)'(wr_en) - (PtrWidth+1)'(rd_en);
    end
  end

endmodule

[hdl/fcsg_back.sv]
module fcsg_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    req_valid,
  output logic                                    req_take,
  input  fcsg_pkg::req_t                          req,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [fcsg_pkg::SpanXyWidth-1:0] span_x,
  output logic signed [fcsg_pkg::SpanXyWidth-1:0] span_y,
  output logic [fcsg_pkg::SpanWWidth-1:0]         span_width,
  output logic [fcsg_pkg::ColourWidth-1:0]        span_colour,
  output logic                                    last_span
);
  import fcsg_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t                     state;
  logic [CoordWidth-1:0]      cx;
  logic [CoordWidth-1:0]      cy;
  logic [ColourWidth-1:0]     colour;
  logic signed [PosWidth-1:0] x;
  logic signed [PosWidth-1:0] y;
  logic signed [DecWidth-1:0] d;
  logic [1:0]                 phase;
  logic [StepWidth-1:0]       steps;
  logic                       out_valid;

  logic                       advance;
  logic signed [SpanXyWidth-1:0] cx_s, cy_s, x_s, y_s;
  logic signed [SpanXyWidth-1:0] sx_next, sy_next;
  logic [SpanWWidth-1:0]         w_next;
  logic signed [DecWidth-1:0]    x_d, y_d, d_next;
  logic signed [PosWidth-1:0]    x_next, y_next;
  logic                          more;
  logic                          last_next;

  assign advance  = !out_valid || pop;
  assign req_take = (state == IDLE) && req_valid;
  assign empty    = !out_valid;

  always_comb begin
    cx_s = $signed({2'b00, cx});
    cy_s = $signed({2'b00, cy});
    x_s  = SpanXyWidth'(x);
    y_s  = SpanXyWidth'(y);
    x_d  = DecWidth'(x);
    y_d  = DecWidth'(y);
    case (phase)
      2'd0: begin
        sx_next = cx_s - x_s;
        sy_next = cy_s - y_s;
        w_next  = {x[SpanWWidth-2:0], 1'b1};
      end
      2'd1: begin
        sx_next = cx_s - x_s;
        sy_next = cy_s + y_s;
        w_next  = {x[SpanWWidth-2:0], 1'b1};
      end
      2'd2: begin
        sx_next = cx_s - y_s;
        sy_next = cy_s - x_s;
        w_next  = {y[SpanWWidth-2:0], 1'b1};
      end
      default: begin
        sx_next = cx_s - y_s;
        sy_next = cy_s + x_s;
        w_next  = {y[SpanWWidth-2:0], 1'b1};
      end
    endcase
    // Midpoint update after the fourth span of a step.
    if (d < 0) begin
      d_next = d + (x_d <<< 2) + DecWidth'(6);
      y_next = y;
    end else begin
      d_next = d + ((x_d - y_d) <<< 2) + DecWidth'(10);
      y_next = y - 1'b1;
    end
    x_next    = x + 1'b1;
    more      = (y_next >= x_next) && (steps != StepWidth'(StepLimit-1));
    last_next = (phase == 2'd3) && !more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      phase     <= '0;
      steps     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (pop) begin
            out_valid <= 1'b0;
          end
          if (req_valid) begin
            cx     <= req.cx;
            cy     <= req.cy;
            colour <= req.colour;
            x      <= '0;
            y      <= PosWidth'(req.r);
            d      <= req.d0;
            phase  <= '0;
            steps  <= '0;
            state  <= RUN;
          end
        end
        RUN: begin
          if (advance) begin
            out_valid   <= 1'b1;
            span_x      <= sx_next;
            span_y      <= sy_next;
            span_width  <= w_next;
            span_colour <= colour;
            last_span   <= last_next;
            phase       <= phase + 1'b1;
            if (phase == 2'd3) begin
              x     <= x_next;
              y     <= y_next;
              d     <= d_next;
              steps <= steps + 1'b1;
              if (!more) begin
                state <= IDLE;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_run_y_ge_x: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (y >= x))
    else $error("span loop running with y below x");

  a_run_y_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (y >= 0))
    else $error("negative y while running");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == RUN && advance && last_next) |=> (state == IDLE && out_valid && last_span))
    else $error("last span did not end the disc");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    req_take |-> (state == IDLE && req_valid))
    else $error("request taken while busy");

endmodule

[hdl/filled_circle_span_generator.sv]
// Filled-disc span generator. Each transfer on the request side describes one disc
// (centre, radius, 24-bit colour); the block answers with a run of one-pixel-high
// horizontal spans that together cover the disc, using the midpoint circle
// recurrence. Each midpoint step gives four spans: widths 2x+1 at rows cy-y and
// cy+y, then widths 2y+1 at rows cy-x and cy+x. Spans that repeat (at x = 0 or
// x = y) are sent as they fall; the final span of a disc has last_span set. A
// radius above MAX_RADIUS is clamped to it. Span coordinates are two's complement
// and may fall left of or above the screen. Rate: the span sequencer sends one span
// per cycle while pop keeps up, and passes through IDLE to load each request; a
// disc takes about 0.71r + 1 steps (15 steps and 60 spans at radius 20); a step
// guard caps a disc at 16 steps and 64 spans. A two-entry request queue sits in
// front of the sequencer, so up to two further requests are taken while a disc is
// drawn.
module filled_circle_span_generator #(
  parameter int MAX_RADIUS = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Request side
  input  logic                                    push,
  output logic                                    full,
  input  logic [fcsg_pkg::CoordWidth-1:0]         centre_x,
  input  logic [fcsg_pkg::CoordWidth-1:0]         centre_y,
  input  logic [fcsg_pkg::RadiusWidth-1:0]        radius,
  input  logic [fcsg_pkg::ColourWidth-1:0]        fill_colour,
  // Span side
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [fcsg_pkg::SpanXyWidth-1:0] span_x,
  output logic signed [fcsg_pkg::SpanXyWidth-1:0] span_y,
  output logic [fcsg_pkg::SpanWWidth-1:0]         span_width,
  output logic [fcsg_pkg::ColourWidth-1:0]        span_colour,
  output logic                                    last_span
);
  import fcsg_pkg::*;

  // Handoff between the request queue and the span sequencer.
  req_t req;
  logic req_valid;
  logic req_take;

  // Front: clamp the radius, seed the decision term, hold requests in the queue.
  fcsg_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .centre_x    (centre_x),
    .centre_y    (centre_y),
    .radius      (radius),
    .fill_colour (fill_colour),
    .req_valid   (req_valid),
    .req_take    (req_take),
    .req         (req)
  );

  // Back: step recurrence; output register takes one span per cycle unless stalled.
  fcsg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_take    (req_take),
    .req         (req),
    .empty       (empty),
    .pop         (pop),
    .span_x      (span_x),
    .span_y      (span_y),
    .span_width  (span_width),
    .span_colour (span_colour),
    .last_span   (last_span)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import fcsg_pkg::*;

  localparam int MaxRadius   = 20;
  localparam int RandomDiscs = 330;
  // Nothing transfers on either side for this many cycles: the block is hung.
  localparam int IdleLimit   = 2000;
  // Leave room after the last predicted span to catch any stray span.
  localparam int DrainCycles = 80;

  // One disc request as it is offered on the request side.
  typedef struct packed {
    logic [CoordWidth-1:0]  cx;
    logic [CoordWidth-1:0]  cy;
    logic [RadiusWidth-1:0] r;
    logic [ColourWidth-1:0] colour;
  } disc_t;

  // One horizontal span as it leaves the block.
  typedef struct packed {
    logic signed [SpanXyWidth-1:0] x;
    logic signed [SpanXyWidth-1:0] y;
    logic [SpanWWidth-1:0]         w;
    logic [ColourWidth-1:0]        colour;
    logic                          last;
  } span_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic [CoordWidth-1:0]         centre_x = '0;
  logic [CoordWidth-1:0]         centre_y = '0;
  logic [RadiusWidth-1:0]        radius = '0;
  logic [ColourWidth-1:0]        fill_colour = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic signed [SpanXyWidth-1:0] span_x;
  logic signed [SpanXyWidth-1:0] span_y;
  logic [SpanWWidth-1:0]         span_width;
  logic [ColourWidth-1:0]        span_colour;
  logic                          last_span;

  // Discs waiting to be offered, and spans the block still owes us, oldest first.
  disc_t disc_requests[$];
  span_t pending_spans[$];

  int errors         = 0;
  int discs_total    = 0;
  int discs_sent     = 0;
  int spans_checked  = 0;
  int clamped_discs  = 0;
  int idle_cycles    = 0;

  filled_circle_span_generator #(
    .MAX_RADIUS(MaxRadius)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .centre_x   (centre_x),
    .centre_y   (centre_y),
    .radius     (radius),
    .fill_colour(fill_colour),
    .empty      (empty),
    .pop        (pop),
    .span_x     (span_x),
    .span_y     (span_y),
    .span_width (span_width),
    .span_colour(span_colour),
    .last_span  (last_span)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Span predictor: midpoint circle fill, written out at the block's widths.
  // ---------------------------------------------------------------------------

  // Wrap a span to the port widths; coordinates are two's complement and may go
  // negative (left of / above the screen) or past 2047.
  function automatic span_t make_span(input disc_t req, input int sx, input int sy,
                                      input int sw);
    span_t sp;
    sp.x      = sx[SpanXyWidth-1:0];
    sp.y      = sy[SpanXyWidth-1:0];
    sp.w      = sw[SpanWWidth-1:0];
    sp.colour = req.colour;
    sp.last   = 1'b0;
    return sp;
  endfunction

  function automatic void append_disc_spans(input disc_t req);
    span_t disc_spans[$];
    int    rad;
    int    dec;
    int    px;
    int    py;
    int    cx;
    int    cy;
    cx  = int'(req.cx);
    cy  = int'(req.cy);
    rad = int'(req.r);
    // Clamp an oversized radius before the recurrence starts.
    if (rad > MaxRadius) begin
      rad = MaxRadius;
      clamped_discs++;
    end
    dec = 3 - 2 * rad;
    px  = 0;
    py  = rad;
    // Four spans per step; duplicates at px == 0 or px == py stay in. The step
    // guard caps a disc at MaxSpans spans.
    while (py >= px && disc_spans.size() + 4 <= MaxSpans) begin
      disc_spans.push_back(make_span(req, cx - px, cy - py, 2 * px + 1));
      disc_spans.push_back(make_span(req, cx - px, cy + py, 2 * px + 1));
      disc_spans.push_back(make_span(req, cx - py, cy - px, 2 * py + 1));
      disc_spans.push_back(make_span(req, cx - py, cy + px, 2 * py + 1));
      if (dec < 0) begin
        dec = dec + 4 * px + 6;
      end else begin
        dec = dec + 4 * (px - py) + 10;
        py--;
      end
      px++;
    end
    disc_spans[disc_spans.size() - 1].last = 1'b1;
    foreach (disc_spans[i]) pending_spans.push_back(disc_spans[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic void add_disc(input int cx, input int cy, input int r,
                                   input int colour);
    disc_t req;
    req.cx     = cx[CoordWidth-1:0];
    req.cy     = cy[CoordWidth-1:0];
    req.r      = r[RadiusWidth-1:0];
    req.colour = colour[ColourWidth-1:0];
    disc_requests.push_back(req);
  endfunction

  // Mostly legal radii across the whole range, with weight on the tiny ones, the
  // bound itself and clamped values; centres mostly anywhere, sometimes hugging
  // an edge so spans wrap negative or past the screen.
  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 6) return $urandom_range(0, 24);
    if (sel == 7) return $urandom_range(2023, 2047);
    return $urandom_range(0, 2047);
  endfunction

  function automatic int pick_radius();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      6:       return $urandom_range(0, 3);
      7:       return MaxRadius;
      8:       return $urandom_range(MaxRadius + 1, 31);
      9:       return $urandom_range(16, MaxRadius);
      default: return $urandom_range(0, MaxRadius);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offer discs in bursts with random gaps, hold while full.
  // ---------------------------------------------------------------------------
  disc_t offer;
  int    burst_left = 0;
  int    gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      // A transfer happened on this edge: predict its spans right away.
      if (push && !full) begin
        append_disc_spans(offer);
        discs_sent++;
      end
      // Hold the current offer while the block is full; otherwise advance.
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (disc_requests.size() > 0) begin
          offer = disc_requests.pop_front();
          centre_x    <= offer.cx;
          centre_y    <= offer.cy;
          radius      <= offer.r;
          fill_colour <= offer.colour;
          push        <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // New burst; a quarter of them follow with no gap and run long.
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(10, 30);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left   = $urandom_range(1, 15);
            end
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Span monitor: check every transfer against the oldest prediction, and stall
  // pop on a pattern that changes mode every so often.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ERROR: span %0d field %s expected %0d actual %0d",
               $time, spans_checked, name, want, got);
    end
  endfunction

  span_t want_span;
  int    stall_mode  = 0;
  int    mode_cycles = 0;
  int    stall_run   = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_mode  = 0;
      mode_cycles = 0;
      stall_run   = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_spans.size() == 0) begin
          errors++;
          $display("%0t ERROR: unexpected span x=%0d y=%0d w=%0d colour=%06h last=%0b",
                   $time, span_x, span_y, span_width, span_colour, last_span);
        end else begin
          want_span = pending_spans.pop_front();
          check_field("span_x", int'(want_span.x), int'(span_x));
          check_field("span_y", int'(want_span.y), int'(span_y));
          check_field("span_width", int'(want_span.w), int'(span_width));
          check_field("span_colour", int'(want_span.colour), int'(span_colour));
          check_field("last_span", int'(want_span.last), int'(last_span));
        end
        spans_checked++;
      end
      // Mode 0 never stalls; the others alternate, throttle at random, or stall
      // in runs long enough to back the block up into its request queue.
      mode_cycles++;
      if (mode_cycles >= 150) begin
        mode_cycles = 0;
        stall_mode  = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= mode_cycles[0];
        2: pop <= ($urandom_range(0, 99) < 60);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Watchdog: end the run if neither side sees a transfer for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t ERROR: no transfer for %0d cycles, %0d spans outstanding",
               $time, IdleLimit, pending_spans.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  disc_t rnd;

  initial begin
    // Directed: zero radius at both corners, the smallest discs, full-size discs
    // at each corner (spans wrap negative and past the screen), clamped radii,
    // colour extremes and alternating bit patterns, and a run of tiny discs
    // back to back to fill the request queue.
    add_disc(0, 0, 0, 24'h000000);
    add_disc(2047, 2047, 0, 24'hFFFFFF);
    add_disc(1024, 1024, 1, 24'hAAAAAA);
    add_disc(1000, 500, 2, 24'h555555);
    add_disc(300, 700, 3, 24'hFF0000);
    add_disc(640, 480, 4, 24'h00FF00);
    add_disc(1365, 682, 5, 24'h0000FF);
    add_disc(0, 0, MaxRadius, 24'h123456);
    add_disc(2047, 2047, MaxRadius, 24'hFEDCBA);
    add_disc(0, 2047, MaxRadius, 24'h800001);
    add_disc(2047, 0, MaxRadius, 24'h7FFFFE);
    add_disc(100, 100, MaxRadius + 1, 24'h0F0F0F);
    add_disc(2047, 0, 31, 24'hF0F0F0);
    add_disc(10, 2040, 16, 24'h00FFFF);
    add_disc(1500, 20, 10, 24'hFF00FF);
    add_disc(777, 1111, 7, 24'hFFFF00);
    add_disc(5, 5, 0, 24'h010203);
    add_disc(6, 6, 0, 24'h040506);
    add_disc(7, 7, 1, 24'h070809);

    // Random discs.
    for (int i = 0; i < RandomDiscs; i++) begin
      rnd.cx     = CoordWidth'(pick_coord());
      rnd.cy     = CoordWidth'(pick_coord());
      rnd.r      = RadiusWidth'(pick_radius());
      rnd.colour = ColourWidth'($urandom());
      disc_requests.push_back(rnd);
    end
    discs_total = disc_requests.size();

    // Hold reset at the start, then release it once for good.
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every disc to transfer, for all predicted spans to arrive, then
    // drain a while longer so a stray span still gets caught.
    while (discs_sent < discs_total) @(posedge clk);
    while (pending_spans.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Drew %0d discs (%0d with radius clamped to %0d), checked %0d spans.",
             discs_sent, clamped_discs, MaxRadius, spans_checked);
    $display("Mismatches: %0d, spans still owed: %0d", errors, pending_spans.size());
    if (errors == 0 && pending_spans.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
